@@ design/fbpa_pkg.sv @@
package fbpa_pkg;

    localparam int DATA_W      = 32;
    localparam int SHIFT_W     = 5;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd3;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT = 2'd2;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_OWNED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_READ  = 3'b010,
        BK_CLEAR = 3'b100
    } t_back_state;

    // register value clamped into the meaningful shift range
    function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] raw);
        logic [SHIFT_W-1:0] sh;
        sh = raw;
        if (raw < SHIFT_MIN) begin
            sh = SHIFT_MIN;
        end else if (raw > SHIFT_MAX) begin
            sh = SHIFT_MAX;
        end
        return sh;
    endfunction

    function automatic logic [DATA_W-1:0] block_bytes(input logic [SHIFT_W-1:0] sh);
        return 32'd1 << sh;
    endfunction

endpackage

@@ design/fbpa_front.sv @@
module fbpa_front #(
    parameter int BLOCKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_address,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_request_size,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_buffer_base,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_buffer_size,
    input  logic [fbpa_pkg::SHIFT_W-1:0]  i_shift,
    input  logic                          i_q_full,
    output logic                          o_push,
    output fbpa_pkg::t_mode               o_cmd_mode,
    output logic                          o_cmd_ok,
    output logic [$clog2(BLOCKS+1)-1:0]   o_cmd_idx
);

    localparam int LINK_W = $clog2(BLOCKS + 1);

    logic                        r_valid, n_valid;
    logic                        r_phase, n_phase;
    fbpa_pkg::t_mode             r_mode;
    logic [fbpa_pkg::DATA_W-1:0] r_addr;
    logic [fbpa_pkg::DATA_W-1:0] r_rsize;
    logic [fbpa_pkg::DATA_W:0]   r_end;
    logic [fbpa_pkg::DATA_W:0]   r_lim;
    logic [fbpa_pkg::DATA_W:0]   r_off;
    logic                        r_size_eq;

    logic                        accept;
    logic [fbpa_pkg::DATA_W-1:0] bsize;
    logic [fbpa_pkg::DATA_W-1:0] idx_raw;
    logic [fbpa_pkg::DATA_W-1:0] blocks_raw;
    logic                        aligned;
    logic [LINK_W-1:0]           clear_n;

    always_comb begin
        bsize      = fbpa_pkg::block_bytes(i_shift);
        idx_raw    = r_off[fbpa_pkg::DATA_W-1:0] >> i_shift;
        blocks_raw = i_buffer_size >> i_shift;
        aligned    = (r_off[fbpa_pkg::DATA_W-1:0] & (bsize - 32'd1)) == 32'd0;
        clear_n    = (blocks_raw > 32'(BLOCKS)) ? LINK_W'(BLOCKS)
                                                : blocks_raw[LINK_W-1:0];

        // borrow set means the address lies below the buffer
        o_cmd_ok   = !r_off[fbpa_pkg::DATA_W] && (r_end <= r_lim) && r_size_eq
                     && aligned && (idx_raw < 32'(BLOCKS));
        o_cmd_mode = r_mode;
        o_cmd_idx  = (r_mode == fbpa_pkg::MODE_CLEAR) ? clear_n : idx_raw[LINK_W-1:0];
        o_push     = r_valid && r_phase && !i_q_full;
        o_in_stall = r_valid && !o_push;
        accept     = i_in_valid && !o_in_stall;

        n_valid = r_valid;
        n_phase = r_phase;
        if (accept) begin
            n_valid = 1'b1;
            n_phase = 1'b0;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else if (r_valid) begin
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= fbpa_pkg::t_mode'(i_mode);
            r_addr  <= i_address;
            r_rsize <= i_request_size;
        end
        if (r_valid && !r_phase) begin
            r_end     <= {1'b0, r_addr} + {1'b0, r_rsize};
            r_lim     <= {1'b0, i_buffer_base} + {1'b0, i_buffer_size};
            r_off     <= {1'b0, r_addr} - {1'b0, i_buffer_base};
            r_size_eq <= r_rsize == bsize;
        end
    end

endmodule

@@ design/fbpa_queue.sv @@
module fbpa_queue #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        o_full  = r_cnt == CNT_W'(DEPTH);
        o_empty = r_cnt == '0;
        o_data  = r_entry[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;

        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr] <= i_data;
        end
    end

endmodule

@@ design/fbpa_back.sv @@
module fbpa_back #(
    parameter int BLOCKS       = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  fbpa_pkg::t_mode               i_cmd_mode,
    input  logic                          i_cmd_ok,
    input  logic [$clog2(BLOCKS+1)-1:0]   i_cmd_idx,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_buffer_base,
    input  logic [fbpa_pkg::DATA_W-1:0]   i_buffer_size,
    input  logic [fbpa_pkg::SHIFT_W-1:0]  i_shift,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [fbpa_pkg::DATA_W-1:0]   o_block_address,
    output logic [fbpa_pkg::DATA_W-1:0]   o_used_bytes_out,
    output logic [fbpa_pkg::DATA_W-1:0]   o_available_bytes
);

    localparam int LINK_W = $clog2(BLOCKS + 1);
    localparam int IDX_W  = $clog2(BLOCKS);
    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(BLOCKS);
    localparam logic [fbpa_pkg::DATA_W-1:0] ADDR_MASK =
        (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

    logic [LINK_W-1:0] r_link [BLOCKS];
    logic [LINK_W-1:0] r_rd_data;

    fbpa_pkg::t_back_state       r_state, n_state;
    logic [LINK_W-1:0]           r_head, n_head;
    logic [LINK_W-1:0]           r_total, n_total;
    logic [fbpa_pkg::DATA_W-1:0] r_used, n_used;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [LINK_W-1:0]           r_cnt, n_cnt;
    logic [LINK_W-1:0]           r_n, n_n;
    logic                        r_out_valid, n_out_valid;
    fbpa_pkg::t_status           r_out_status, n_out_status;
    logic [fbpa_pkg::DATA_W-1:0] r_out_addr, n_out_addr;

    logic                        out_free;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_wa;
    logic [LINK_W-1:0]           mem_wd;
    logic [IDX_W-1:0]            mem_ra;
    logic [fbpa_pkg::DATA_W-1:0] bsize;
    logic [fbpa_pkg::DATA_W:0]   used_sum;
    logic [LINK_W-1:0]           cnt_next;

    always_comb begin
        bsize    = fbpa_pkg::block_bytes(i_shift);
        used_sum = {1'b0, r_used} + {1'b0, bsize};
        cnt_next = r_cnt + 1'b1;
        // the output register is free after this edge
        out_free = !r_out_valid || !i_out_stall;

        n_state      = r_state;
        n_head       = r_head;
        n_total      = r_total;
        n_used       = r_used;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_n          = r_n;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        mem_ra       = r_head[IDX_W-1:0];
        o_q_pop      = 1'b0;

        case (r_state)
            fbpa_pkg::BK_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_q_pop = 1'b1;
                    case (i_cmd_mode)
                        fbpa_pkg::MODE_ALLOC: begin
                            if (r_head != LIST_END) begin
                                // link of the head block arrives next cycle
                                n_idx   = r_head[IDX_W-1:0];
                                n_state = fbpa_pkg::BK_READ;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_status = fbpa_pkg::ST_EMPTY;
                                n_out_addr   = '0;
                            end
                        end
                        fbpa_pkg::MODE_FREE: begin
                            n_out_valid = 1'b1;
                            n_out_addr  = '0;
                            if (i_cmd_ok && (i_cmd_idx < r_total)) begin
                                mem_we       = 1'b1;
                                mem_wa       = i_cmd_idx[IDX_W-1:0];
                                mem_wd       = r_head;
                                n_head       = i_cmd_idx;
                                n_used       = (r_used > bsize) ? r_used - bsize : '0;
                                n_out_status = fbpa_pkg::ST_DONE;
                            end else begin
                                n_out_status = fbpa_pkg::ST_NOT_OWNED;
                            end
                        end
                        fbpa_pkg::MODE_CLEAR: begin
                            n_cnt   = '0;
                            n_n     = i_cmd_idx;
                            n_state = fbpa_pkg::BK_CLEAR;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_status = fbpa_pkg::ST_DONE;
                            n_out_addr   = '0;
                        end
                    endcase
                end
            end
            fbpa_pkg::BK_READ: begin
                n_head       = r_rd_data;
                n_used       = used_sum[fbpa_pkg::DATA_W] ? '1 : used_sum[fbpa_pkg::DATA_W-1:0];
                n_out_valid  = 1'b1;
                n_out_status = fbpa_pkg::ST_DONE;
                n_out_addr   = (i_buffer_base + (32'(r_idx) << i_shift)) & ADDR_MASK;
                n_state      = fbpa_pkg::BK_IDLE;
            end
            fbpa_pkg::BK_CLEAR: begin
                if (r_cnt == r_n) begin
                    n_head       = (r_n == '0) ? LIST_END : '0;
                    n_total      = r_n;
                    n_used       = '0;
                    n_out_valid  = 1'b1;
                    n_out_status = fbpa_pkg::ST_DONE;
                    n_out_addr   = '0;
                    n_state      = fbpa_pkg::BK_IDLE;
                end else begin
                    // relink in ascending order, last block ends the list
                    mem_we = 1'b1;
                    mem_wa = r_cnt[IDX_W-1:0];
                    mem_wd = (cnt_next < r_n) ? cnt_next : LIST_END;
                    n_cnt  = cnt_next;
                end
            end
            default: begin
                n_state = fbpa_pkg::BK_IDLE;
            end
        endcase

        o_out_valid       = r_out_valid;
        o_status          = r_out_status;
        o_block_address   = r_out_addr;
        o_used_bytes_out  = r_used;
        o_available_bytes = (i_buffer_size > r_used) ? i_buffer_size - r_used : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbpa_pkg::BK_IDLE;
            r_head      <= LIST_END;
            r_total     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_total     <= n_total;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_n          <= n_n;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_link[mem_ra];
    end

endmodule

@@ design/fixed_block_pool_allocator.sv @@
// Fixed-size block pool kept as a linked free list of block indices in a link
// memory of BLOCKS entries. Mode 0 pops the list head and returns its byte address,
// mode 1 checks that an address is an owned, aligned block of the configured size
// and pushes it, mode 2 relinks every block in ascending order and zeroes the used
// count. Every transaction returns one result with the used and available bytes.
// A front stage classifies each transaction first by address sums, then by
// ownership compares, and feeds a two-entry queue; the back end does an allocate
// with one registered read of the link memory and a clear of n blocks, where
// n = min(buffer_size >> block_shift, BLOCKS), by writing one link per cycle
// through the single write port. The front stage takes a new transaction once
// its last one is pushed to the queue. Until the first clear the pool is empty.
// Configuration writes are taken at any time but must only be issued while idle.
module fixed_block_pool_allocator #(
    parameter int BLOCKS       = 1024,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [fbpa_pkg::DATA_W-1:0]       i_address,
    input  logic [fbpa_pkg::DATA_W-1:0]       i_request_size,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [fbpa_pkg::DATA_W-1:0]       o_block_address,
    output logic [fbpa_pkg::DATA_W-1:0]       o_used_bytes_out,
    output logic [fbpa_pkg::DATA_W-1:0]       o_available_bytes,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::DATA_W-1:0]       i_cfg_data
);

    localparam int LINK_W = $clog2(BLOCKS + 1);
    localparam int CMD_W  = 2 + 1 + LINK_W;

    logic [fbpa_pkg::DATA_W-1:0]  r_buffer_base;
    logic [fbpa_pkg::DATA_W-1:0]  r_buffer_size;
    logic [fbpa_pkg::SHIFT_W-1:0] r_block_shift;
    logic [fbpa_pkg::SHIFT_W-1:0] shift;

    logic                         push;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    fbpa_pkg::t_mode              f_mode;
    logic                         f_ok;
    logic [LINK_W-1:0]            f_idx;
    logic [CMD_W-1:0]             q_data;
    fbpa_pkg::t_mode              b_mode;
    logic                         b_ok;
    logic [LINK_W-1:0]            b_idx;

    assign o_cfg_ready = 1'b1;
    assign shift       = fbpa_pkg::eff_shift(r_block_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_base <= '0;
            r_buffer_size <= '0;
            r_block_shift <= fbpa_pkg::SHIFT_MIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fbpa_pkg::CFG_BASE:  r_buffer_base <= i_cfg_data;
                fbpa_pkg::CFG_SIZE:  r_buffer_size <= i_cfg_data;
                fbpa_pkg::CFG_SHIFT: r_block_shift <= i_cfg_data[fbpa_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    fbpa_front #(
        .BLOCKS (BLOCKS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_request_size (i_request_size),
        .i_buffer_base  (r_buffer_base),
        .i_buffer_size  (r_buffer_size),
        .i_shift        (shift),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd_mode     (f_mode),
        .o_cmd_ok       (f_ok),
        .o_cmd_idx      (f_idx)
    );

    fbpa_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_mode, f_ok, f_idx}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign b_mode = fbpa_pkg::t_mode'(q_data[CMD_W-1 -: 2]);
    assign b_ok   = q_data[LINK_W];
    assign b_idx  = q_data[LINK_W-1:0];

    fbpa_back #(
        .BLOCKS       (BLOCKS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .o_q_pop           (q_pop),
        .i_cmd_mode        (b_mode),
        .i_cmd_ok          (b_ok),
        .i_cmd_idx         (b_idx),
        .i_buffer_base     (r_buffer_base),
        .i_buffer_size     (r_buffer_size),
        .i_shift           (shift),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_block_address   (o_block_address),
        .o_used_bytes_out  (o_used_bytes_out),
        .o_available_bytes (o_available_bytes)
    );

endmodule
